[hw/rtl/hdgpw_pkg.sv]
package hdgpw_pkg;

  // Screen geometry
  localparam int SCREEN_W = 320;
  localparam int SCREEN_H = 200;

  // Glyph geometry
  localparam int GLYPH_W = 4;
  localparam int GLYPH_H = 8;
  localparam int COL_W   = $clog2(GLYPH_W);
  localparam int ROW_W   = $clog2(GLYPH_H);
  localparam int CNT_W   = COL_W + ROW_W;
  localparam int PIX_PER_GLYPH = GLYPH_W * GLYPH_H;

  // Field widths
  localparam int DIGIT_W  = 4;
  localparam int POS_X_W  = 9;
  localparam int POS_Y_W  = 8;
  localparam int OFFSET_W = 16;
  localparam int COLOR_W  = 8;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Clamp limits that keep the whole glyph on screen
  localparam logic [POS_X_W-1:0] X_MAX = POS_X_W'(SCREEN_W - GLYPH_W);
  localparam logic [POS_Y_W-1:0] Y_MAX = POS_Y_W'(SCREEN_H - GLYPH_H);

  localparam logic [CNT_W-1:0]   CNT_LAST    = CNT_W'(PIX_PER_GLYPH - 1);
  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd15;

  // Offset step when the scan wraps from the last column to the next row
  localparam logic [OFFSET_W-1:0] ROW_STEP = OFFSET_W'(SCREEN_W - GLYPH_W + 1);
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = OFFSET_W'(SCREEN_W * SCREEN_H - 1);

  // One glyph in flight: clamped position and the pixel being produced
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [POS_X_W-1:0] x;
    logic [POS_Y_W-1:0] y;
    logic [CNT_W-1:0]   cnt;
  } pix_req_t;

  // Font ROM: four column bytes per glyph, column 0 in the low byte.
  // Bit 7 of a column byte is the top row.
  function automatic logic [GLYPH_W*8-1:0] font_glyph(input logic [DIGIT_W-1:0] d);
    logic [GLYPH_W*8-1:0] g;
    case (d)
      4'h0: g = {8'h7e, 8'h81, 8'h81, 8'h7e};
      4'h1: g = {8'h01, 8'hff, 8'h41, 8'h00};
      4'h2: g = {8'h61, 8'h91, 8'h89, 8'h47};
      4'h3: g = {8'h66, 8'h99, 8'h81, 8'h42};
      4'h4: g = {8'h08, 8'hff, 8'h48, 8'h38};
      4'h5: g = {8'h8d, 8'h91, 8'h91, 8'hfa};
      4'h6: g = {8'h46, 8'h89, 8'h89, 8'h7d};
      4'h7: g = {8'hc0, 8'hb0, 8'h8c, 8'hc3};
      4'h8: g = {8'h66, 8'h99, 8'h99, 8'h66};
      4'h9: g = {8'hff, 8'h90, 8'h90, 8'h60};
      4'ha: g = {8'h3f, 8'hc8, 8'hc8, 8'h3f};
      4'hb: g = {8'h66, 8'h99, 8'h99, 8'hff};
      4'hc: g = {8'h66, 8'h81, 8'h81, 8'h7e};
      4'hd: g = {8'h7e, 8'hc3, 8'h81, 8'hff};
      4'he: g = {8'h99, 8'h99, 8'h99, 8'hff};
      4'hf: g = {8'h88, 8'h88, 8'h88, 8'hff};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

[hw/rtl/hex_digit_glyph_pixel_writer.sv]
// Hex digit glyph pixel writer.
//
// The slave stream takes one glyph request per transaction: a hex digit and
// the top-left screen position. Positions beyond the screen are clamped so
// the whole 4x8 glyph stays visible. The master stream gives 32 pixel
// writes per request, rows top to bottom and columns left to right; each
// carries the linear frame-buffer offset and either the pixel color or zero.
// tlast marks the 32nd pixel of each glyph.
//
// The config channel writes the pixel color; it is always ready and should
// only be written while no glyph is in flight.
//
// Each request is held in the item register and each pixel then passes
// through the output register. Throughput: one pixel per cycle while the
// receiver is ready; a new request is taken in the same cycle the last
// pixel of the previous one enters the output register, so glyphs stream
// without gaps. The pixel counter in the item register sets that rate.
// When the receiver stalls, the output register holds its transaction and
// the counter stops. Reset empties both stages and sets the color to 15.
module hex_digit_glyph_pixel_writer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // digit [3:0], pos_x [12:4], pos_y [20:13], zero [23:21]
  input  logic [hdgpw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pixel_offset [15:0], pixel_value [23:16]
  output logic [hdgpw_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hdgpw_pkg::COLOR_W-1:0]     cfg_data
);
  import hdgpw_pkg::*;

  logic [COLOR_W-1:0]  pixel_color;
  logic                req_valid;
  logic                req_ready;
  pix_req_t            req;
  logic [OFFSET_W-1:0] pixel_offset;
  logic [COLOR_W-1:0]  pixel_value;

  // Color register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_color <= COLOR_RESET;
    end else if (cfg_valid) begin
      pixel_color <= cfg_data;
    end
  end

  hdgpw_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_digit  (s_axis_tdata[DIGIT_W-1:0]),
    .in_x      (s_axis_tdata[DIGIT_W +: POS_X_W]),
    .in_y      (s_axis_tdata[DIGIT_W+POS_X_W +: POS_Y_W]),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req)
  );

  hdgpw_out u_out (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .color      (pixel_color),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_offset (pixel_offset),
    .out_value  (pixel_value),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {pixel_value, pixel_offset};

endmodule

[hw/rtl/hdgpw_seq.sv]
module hdgpw_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hdgpw_pkg::DIGIT_W-1:0] in_digit,
  input  logic [hdgpw_pkg::POS_X_W-1:0] in_x,
  input  logic [hdgpw_pkg::POS_Y_W-1:0] in_y,
  output logic                        req_valid,
  input  logic                        req_ready,
  output hdgpw_pkg::pix_req_t         req
);
  import hdgpw_pkg::*;

  logic     busy;
  pix_req_t item;
  logic     adv;
  logic     done;

  // The current pixel moves on when the output stage takes it.
  assign adv      = busy && req_ready;
  assign done     = adv && (item.cnt == CNT_LAST);
  assign in_ready = !busy || done;

  assign req_valid = busy;
  assign req       = item;

  // Item register with clamped position and pixel counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      item.cnt <= '0;
    end else if (in_valid && in_ready) begin
      busy       <= 1'b1;
      item.digit <= in_digit;
      item.x     <= (in_x > X_MAX) ? X_MAX : in_x;
      item.y     <= (in_y > Y_MAX) ? Y_MAX : in_y;
      item.cnt   <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (adv) begin
      item.cnt <= item.cnt + CNT_W'(1);
    end
  end

endmodule

[hw/rtl/hdgpw_out.sv]
module hdgpw_out (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  hdgpw_pkg::pix_req_t           req,
  input  logic [hdgpw_pkg::COLOR_W-1:0] color,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hdgpw_pkg::OFFSET_W-1:0] out_offset,
  output logic [hdgpw_pkg::COLOR_W-1:0] out_value,
  output logic                          out_last
);
  import hdgpw_pkg::*;

  logic [ROW_W-1:0]     row;
  logic [COL_W-1:0]     col;
  logic [7:0]           col_bits;
  logic                 on;
  logic [POS_Y_W-1:0]   line;
  logic [OFFSET_W-1:0]  offset_next;
  logic [GLYPH_W*8-1:0] glyph;

  assign row = req.cnt[CNT_W-1:COL_W];
  assign col = req.cnt[COL_W-1:0];

  // Font lookup and the glyph bit for this row.
  assign glyph    = font_glyph(req.digit);
  assign col_bits = glyph[col*8 +: 8];
  assign on       = col_bits[3'(GLYPH_H - 1) - row];

  // Linear frame-buffer offset, wrapped to the offset width.
  assign line        = req.y + POS_Y_W'(row);
  assign offset_next = OFFSET_W'(OFFSET_W'(line) * OFFSET_W'(SCREEN_W))
                     + OFFSET_W'(req.x) + OFFSET_W'(col);

  assign req_ready = !out_valid || out_ready;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_ready) begin
      out_valid <= req_valid;
    end
    if (req_ready && req_valid) begin
      out_offset <= offset_next;
      out_value  <= on ? color : '0;
      out_last   <= (req.cnt == CNT_LAST);
    end
  end

endmodule

[hw/rtl/hdgpw_checker.sv]
module hdgpw_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [hdgpw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [hdgpw_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                              m_axis_tlast
);
  import hdgpw_pkg::*;

  // Reset leaves no pixel pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("pixel pending after reset");

  // A stalled pixel holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled pixel changed");

  // Clamping keeps every offset inside the frame buffer.
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[OFFSET_W-1:0] <= OFFSET_MAX))
    else $error("pixel offset beyond frame buffer");

  // Within a glyph the next pixel follows at once, one column or one row on.
  a_scan_step: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid &&
       ((m_axis_tdata[OFFSET_W-1:0] == $past(m_axis_tdata[OFFSET_W-1:0]) + OFFSET_W'(1)) ||
        (m_axis_tdata[OFFSET_W-1:0] == $past(m_axis_tdata[OFFSET_W-1:0]) + ROW_STEP))))
    else $error("glyph scan order broken");

  // The input payload is only checked for unknown bits when a request is taken.
  a_input_known: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> !$isunknown(s_axis_tdata))
    else $error("unknown glyph request");

endmodule

bind hex_digit_glyph_pixel_writer hdgpw_checker u_hdgpw_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
